>>> sv/four_queue_deadline_io_scheduler_defines.svh
// assertion macros for the four-queue deadline scheduler
// no dependencies; included by the top level
`ifndef FOUR_QUEUE_DEADLINE_IO_SCHEDULER_DEFINES_SVH
`define FOUR_QUEUE_DEADLINE_IO_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
// implication checked at every clock edge outside reset
`define FQDS_ASSERT_IMPLY(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("implication failed");
// condition that must never hold outside reset
`define FQDS_ASSERT_NEVER(lbl, ck, rn, a) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(a)) \
        else $error("forbidden condition");
`else
`define FQDS_ASSERT_IMPLY(lbl, ck, rn, a, b)
`define FQDS_ASSERT_NEVER(lbl, ck, rn, a)
`endif
`endif

>>> sv/fqds_pkg.sv
// shared types, codes and helpers of the deadline scheduler
// no dependencies
package fqds_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ENQ  = 2'd1,
        OP_DISP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] REG_SYNC_RD_EXP  = 3'd0;
    localparam logic [2:0] REG_SYNC_WR_EXP  = 3'd1;
    localparam logic [2:0] REG_ASYNC_RD_EXP = 3'd2;
    localparam logic [2:0] REG_ASYNC_WR_EXP = 3'd3;
    localparam logic [2:0] REG_BATCH_LIMIT  = 3'd4;
    localparam logic [2:0] REG_STARVE_LIMIT = 3'd5;

    localparam logic [1:0] Q_ASYNC_RD = 2'd0;
    localparam logic [1:0] Q_ASYNC_WR = 2'd1;
    localparam logic [1:0] Q_SYNC_RD  = 2'd2;
    localparam logic [1:0] Q_SYNC_WR  = 2'd3;

    localparam logic [16:0] BATCH_MAX  = 17'h1FFFF;
    localparam logic [8:0]  STARVE_MAX = 9'h1FF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_tag;
        logic        is_sync;
        logic        is_write;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        dispatched;
        logic [15:0] out_tag;
        logic        out_sync;
        logic        out_write;
        logic        was_expired;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t         op;
        logic [1:0]  qclass;
        logic [15:0] tag;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXP,
        S_FETCH
    } bstate_t;

    // expired scan order: async write, async read, sync write, sync read
    function automatic logic [1:0] exp_class(input logic [1:0] idx);
        return idx ^ 2'd1;
    endfunction

endpackage

>>> sv/fqds_front.sv
// front end: accepts items, classifies them, holds them in a two-entry queue
// depends on fqds_pkg
module fqds_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fqds_pkg::in_item_t  item,
    output logic                cmd_valid,
    output fqds_pkg::cmd_t      cmd,
    input  logic                pop
);

    fqds_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic           do_pop;
    fqds_pkg::cmd_t in_cmd;

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_pop    = pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.op     = fqds_pkg::op_t'(item.opcode);
        in_cmd.qclass = {item.is_sync, item.is_write};
        in_cmd.tag    = item.request_tag;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> sv/fqds_back.sv
// back end: queue memory, time, counters, config and the dispatch sequencer
// depends on fqds_pkg
module fqds_back
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  fqds_pkg::cmd_t     cmd,
    output logic               pop,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output fqds_pkg::result_t  result
);

    localparam int AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW        = AW + 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W     = 32 + TAG_BITS;
    localparam int MEM_DEPTH = 4 * (1 << AW);

    logic [ENT_W-1:0] mem [MEM_DEPTH];
    logic [ENT_W-1:0] rdata_reg;
    logic             rd_en;
    logic [AW+1:0]    rd_addr;
    logic             wr_en;
    logic [AW+1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    fqds_pkg::bstate_t state_reg, state_next;
    logic [AW-1:0]  heads_reg [4];
    logic [AW-1:0]  heads_next [4];
    logic [CW-1:0]  counts_reg [4];
    logic [CW-1:0]  counts_next [4];
    logic [31:0]    time_reg, time_next;
    logic [16:0]    batch_reg, batch_next;
    logic [8:0]     starve_reg, starve_next;
    logic [1:0]     idx_reg, idx_next;
    logic [1:0]     chosen_reg, chosen_next;
    logic           expired_reg, expired_next;
    logic           done_reg, done_next;
    fqds_pkg::result_t result_reg, result_next;

    logic [15:0] sync_rd_exp_reg, sync_wr_exp_reg;
    logic [15:0] async_rd_exp_reg, async_wr_exp_reg;
    logic [15:0] batch_limit_reg;
    logic [7:0]  starve_limit_reg;

    logic [3:0]  nonempty;
    logic        pref;
    logic [1:0]  pref_q;
    logic        pref_found;
    logic [1:0]  scan_q;
    logic        hit;
    logic        batch_over;
    logic [31:0] age;
    logic [31:0] head_dl;
    logic [1:0]  upd_q;
    logic [15:0] cls_exp;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_slot;
    logic [SW-1:0] head_inc;

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nonempty[i] = (counts_reg[i] != '0);
        end
    end

    // preferred-direction pick over queue occupancy
    always_comb
    begin
        pref       = ({1'b0, starve_reg} > {2'b00, starve_limit_reg});
        pref_found = 1'b1;
        if (nonempty[{1'b1, pref}])
        begin
            pref_q = {1'b1, pref};
        end
        else if (nonempty[{1'b1, !pref}])
        begin
            pref_q = {1'b1, !pref};
        end
        else if (nonempty[{1'b0, pref}])
        begin
            pref_q = {1'b0, pref};
        end
        else
        begin
            pref_q     = {1'b0, !pref};
            pref_found = nonempty[{1'b0, !pref}];
        end
    end

    assign batch_over = ({1'b0, batch_limit_reg} < batch_reg);
    assign scan_q     = fqds_pkg::exp_class(idx_reg);
    assign head_dl    = rdata_reg[ENT_W-1 -: 32];
    assign age        = time_reg - head_dl;
    assign hit        = nonempty[scan_q] && !age[31];
    assign upd_q      = (state_reg == fqds_pkg::S_EXP) ? scan_q : chosen_reg;

    always_comb
    begin
        case (cmd.qclass)
            fqds_pkg::Q_ASYNC_RD: cls_exp = async_rd_exp_reg;
            fqds_pkg::Q_ASYNC_WR: cls_exp = async_wr_exp_reg;
            fqds_pkg::Q_SYNC_RD:  cls_exp = sync_rd_exp_reg;
            default:              cls_exp = sync_wr_exp_reg;
        endcase
    end

    always_comb
    begin
        tail_sum = SW'(heads_reg[cmd.qclass]) + SW'(counts_reg[cmd.qclass]);
        if (tail_sum >= SW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        tail_slot = tail_sum[AW-1:0];
        head_inc  = SW'(heads_reg[upd_q]) + SW'(1);
        if (head_inc == SW'(QUEUE_DEPTH))
        begin
            head_inc = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqds_pkg::S_IDLE:
            begin
                if (cmd_valid && cmd.op == fqds_pkg::OP_DISP)
                begin
                    if (batch_over)
                    begin
                        state_next = fqds_pkg::S_EXP;
                    end
                    else if (pref_found)
                    begin
                        state_next = fqds_pkg::S_FETCH;
                    end
                end
            end
            fqds_pkg::S_EXP:
            begin
                if (hit)
                begin
                    state_next = fqds_pkg::S_IDLE;
                end
                else if (idx_reg == 2'd3)
                begin
                    state_next = pref_found ? fqds_pkg::S_FETCH : fqds_pkg::S_IDLE;
                end
            end
            fqds_pkg::S_FETCH: state_next = fqds_pkg::S_IDLE;
            default:           state_next = fqds_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic do_upd;
        do_upd       = 1'b0;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = {pref_q, heads_reg[pref_q]};
        wr_en        = 1'b0;
        wr_addr      = {cmd.qclass, tail_slot};
        wr_data      = {time_reg + {16'd0, cls_exp}, TAG_BITS'(cmd.tag)};
        for (int i = 0; i < 4; i++)
        begin
            heads_next[i]  = heads_reg[i];
            counts_next[i] = counts_reg[i];
        end
        time_next    = time_reg;
        batch_next   = batch_reg;
        starve_next  = starve_reg;
        idx_next     = idx_reg;
        chosen_next  = chosen_reg;
        expired_next = expired_reg;
        done_next    = 1'b0;
        result_next  = '0;

        case (state_reg)
            fqds_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        fqds_pkg::OP_TICK:
                        begin
                            time_next = time_reg + 32'd1;
                            done_next = 1'b1;
                        end
                        fqds_pkg::OP_ENQ:
                        begin
                            done_next = 1'b1;
                            if (counts_reg[cmd.qclass] == CW'(QUEUE_DEPTH))
                            begin
                                result_next.status = fqds_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                counts_next[cmd.qclass] = counts_reg[cmd.qclass] + CW'(1);
                            end
                        end
                        fqds_pkg::OP_DISP:
                        begin
                            if (batch_over)
                            begin
                                batch_next = '0;
                                idx_next   = 2'd0;
                                rd_en      = 1'b1;
                                rd_addr    = {fqds_pkg::exp_class(2'd0),
                                              heads_reg[fqds_pkg::exp_class(2'd0)]};
                            end
                            else if (pref_found)
                            begin
                                rd_en        = 1'b1;
                                chosen_next  = pref_q;
                                expired_next = 1'b0;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = fqds_pkg::ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            fqds_pkg::S_EXP:
            begin
                if (hit)
                begin
                    do_upd                  = 1'b1;
                    result_next.was_expired = 1'b1;
                end
                else if (idx_reg == 2'd3)
                begin
                    if (pref_found)
                    begin
                        rd_en        = 1'b1;
                        chosen_next  = pref_q;
                        expired_next = 1'b0;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        result_next.status = fqds_pkg::ST_EMPTY;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                    rd_en    = 1'b1;
                    rd_addr  = {fqds_pkg::exp_class(idx_reg + 2'd1),
                                heads_reg[fqds_pkg::exp_class(idx_reg + 2'd1)]};
                end
            end
            fqds_pkg::S_FETCH:
            begin
                do_upd                  = 1'b1;
                result_next.was_expired = expired_reg;
            end
            default:
            begin
            end
        endcase

        if (do_upd)
        begin
            done_next              = 1'b1;
            result_next.status     = fqds_pkg::ST_DONE;
            result_next.dispatched = 1'b1;
            result_next.out_tag    = 16'(rdata_reg[TAG_BITS-1:0]);
            result_next.out_sync   = upd_q[1];
            result_next.out_write  = upd_q[0];
            heads_next[upd_q]      = head_inc[AW-1:0];
            counts_next[upd_q]     = counts_reg[upd_q] - CW'(1);
            if (batch_reg != fqds_pkg::BATCH_MAX)
            begin
                batch_next = batch_reg + 17'd1;
            end
            if (upd_q[0])
            begin
                starve_next = '0;
            end
            else if (starve_reg != fqds_pkg::STARVE_MAX)
            begin
                starve_next = starve_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fqds_pkg::S_IDLE;
            for (int i = 0; i < 4; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
            time_reg    <= '0;
            batch_reg   <= '0;
            starve_reg  <= '0;
            idx_reg     <= '0;
            chosen_reg  <= '0;
            expired_reg <= 1'b0;
            done_reg    <= 1'b0;
            sync_rd_exp_reg  <= 16'd100;
            sync_wr_exp_reg  <= 16'd100;
            async_rd_exp_reg <= 16'd200;
            async_wr_exp_reg <= 16'd200;
            batch_limit_reg  <= 16'd16;
            starve_limit_reg <= 8'd1;
        end
        else
        begin
            state_reg   <= state_next;
            for (int i = 0; i < 4; i++)
            begin
                heads_reg[i]  <= heads_next[i];
                counts_reg[i] <= counts_next[i];
            end
            time_reg    <= time_next;
            batch_reg   <= batch_next;
            starve_reg  <= starve_next;
            idx_reg     <= idx_next;
            chosen_reg  <= chosen_next;
            expired_reg <= expired_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fqds_pkg::REG_SYNC_RD_EXP:  sync_rd_exp_reg  <= cfg_data;
                    fqds_pkg::REG_SYNC_WR_EXP:  sync_wr_exp_reg  <= cfg_data;
                    fqds_pkg::REG_ASYNC_RD_EXP: async_rd_exp_reg <= cfg_data;
                    fqds_pkg::REG_ASYNC_WR_EXP: async_wr_exp_reg <= cfg_data;
                    fqds_pkg::REG_BATCH_LIMIT:  batch_limit_reg  <= cfg_data;
                    fqds_pkg::REG_STARVE_LIMIT: starve_limit_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

>>> sv/four_queue_deadline_io_scheduler.sv
// flow: tick, enqueue and unused opcodes pass the two-entry front queue, then the back
// registers done and result; a dispatch past the batch limit runs the expired scan,
// one queue-memory read per head checked; otherwise, or with no hit, it fetches the
// preferred head or reports empty; throughput: one item per cycle for tick and enqueue
// while the back is idle, none taken during a dispatch; done lasts one cycle, no stall
// reset: asynchronous active-low rst_n clears queues, time and counters; config to defaults
`include "four_queue_deadline_io_scheduler_defines.svh"

module four_queue_deadline_io_scheduler
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fqds_pkg::in_item_t item,
    output logic               done,
    output fqds_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // classified item between front and back
    logic           cmd_valid;
    fqds_pkg::cmd_t cmd;
    logic           pop;

    // front: takes items while its small queue has room
    fqds_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop)
    );

    // back: queue memory, deadline scan, dispatch selection and counters
    fqds_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // a dispatched request always reports plain success
    `FQDS_ASSERT_IMPLY(a_disp_status, clk, rst_n, done && result.dispatched,
        result.status == fqds_pkg::ST_DONE)
    // the expired flag only comes with a dispatched request
    `FQDS_ASSERT_IMPLY(a_exp_disp, clk, rst_n, done && result.was_expired,
        result.dispatched)
    // the back never pops an empty front queue
    `FQDS_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !cmd_valid)

endmodule

>>> dv/fqds_checker.sv
// checker for the four-queue deadline scheduler: watches the item and result
// channels and the config port, predicts each result and compares; depends on fqds_pkg
module fqds_checker
    import fqds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    item,
    input  logic        done,
    input  result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int DEPTH = 64;

    logic [47:0] qmem [4][DEPTH];
    int          qhead [4];
    int          qcount [4];
    logic [31:0] now;
    logic [16:0] batch;
    logic [8:0]  starve;
    logic [15:0] expiry [4];
    logic [15:0] batch_lim;
    logic [7:0]  starve_lim;
    result_t     expected_results [$];

    function automatic bit head_is_expired(input logic [1:0] q);
        logic [31:0] diff;
        if (qcount[q] == 0)
            return 0;
        diff = now - qmem[q][qhead[q]][47:16];
        return diff[31] == 1'b0;
    endfunction

    // advance the predicted state by one item and queue its result
    function automatic void schedule_item(input in_item_t it);
        result_t     r;
        logic [1:0]  q;
        logic [1:0]  order [4];
        logic        pref;
        int          chosen;
        int          slot;
        r = '0;
        chosen = -1;
        if (it.opcode == OP_TICK)
            now = now + 1;
        else if (it.opcode == OP_ENQ) begin
            q = {it.is_sync, it.is_write};
            if (qcount[q] >= DEPTH)
                r.status = ST_FULL;
            else begin
                slot = (qhead[q] + qcount[q]) % DEPTH;
                qmem[q][slot] = {now + 32'(expiry[q]), it.request_tag};
                qcount[q]++;
            end
        end
        else if (it.opcode == OP_DISP) begin
            if (batch > 17'(batch_lim)) begin
                batch = '0;
                for (int i = 0; i < 4; i++)
                    if (chosen < 0 && head_is_expired(2'(i) ^ 2'd1)) begin
                        chosen = i ^ 1;
                        r.was_expired = 1'b1;
                    end
            end
            if (chosen < 0) begin
                pref = starve > 9'(starve_lim);
                order[0] = {1'b1, pref};
                order[1] = {1'b1, ~pref};
                order[2] = {1'b0, pref};
                order[3] = {1'b0, ~pref};
                for (int i = 0; i < 4; i++)
                    if (chosen < 0 && qcount[order[i]] != 0)
                        chosen = order[i];
            end
            if (chosen < 0)
                r.status = ST_EMPTY;
            else begin
                q = 2'(chosen);
                r.dispatched = 1'b1;
                r.out_tag = qmem[q][qhead[q]][15:0];
                r.out_sync = q[1];
                r.out_write = q[0];
                qhead[q] = (qhead[q] + 1) % DEPTH;
                qcount[q]--;
                if (batch != BATCH_MAX)
                    batch++;
                if (q[0])
                    starve = '0;
                else if (starve != STARVE_MAX)
                    starve++;
            end
        end
        expected_results.push_back(r);
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            for (int q = 0; q < 4; q++)
            begin
                qhead[q] = 0;
                qcount[q] = 0;
            end
            now = '0;
            batch = '0;
            starve = '0;
            expiry[Q_SYNC_RD] = 16'd100;
            expiry[Q_SYNC_WR] = 16'd100;
            expiry[Q_ASYNC_RD] = 16'd200;
            expiry[Q_ASYNC_WR] = 16'd200;
            batch_lim = 16'd16;
            starve_lim = 8'd1;
            expected_results.delete();
            fail_count = 0;
        end
        else begin
            // results are checked before the new item lands in the queue
            if (done) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", result);
                end
                else begin
                    want = expected_results.pop_front();
                    if (result !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected st=%0d d=%0b tag=%h s=%0b w=%0b x=%0b, got st=%0d d=%0b tag=%h s=%0b w=%0b x=%0b",
                                want.status, want.dispatched, want.out_tag, want.out_sync,
                                want.out_write, want.was_expired, result.status,
                                result.dispatched, result.out_tag, result.out_sync,
                                result.out_write, result.was_expired);
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    REG_SYNC_RD_EXP:  expiry[Q_SYNC_RD] = cfg_data;
                    REG_SYNC_WR_EXP:  expiry[Q_SYNC_WR] = cfg_data;
                    REG_ASYNC_RD_EXP: expiry[Q_ASYNC_RD] = cfg_data;
                    REG_ASYNC_WR_EXP: expiry[Q_ASYNC_WR] = cfg_data;
                    REG_BATCH_LIMIT:  batch_lim = cfg_data;
                    REG_STARVE_LIMIT: starve_lim = cfg_data[7:0];
                    default: ;
                endcase
            if (start && !busy)
                schedule_item(item);
        end
    end
endmodule

>>> dv/four_queue_deadline_io_scheduler_tb.sv
// testbench top for the four-queue deadline scheduler: drives items and config
// writes, instantiates the block and fqds_checker; depends on fqds_pkg
module four_queue_deadline_io_scheduler_tb;
    import fqds_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          stall_cycles;
    int          idle_pct;     // chance in percent that the sender idles a cycle

    four_queue_deadline_io_scheduler i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    fqds_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: cycles with no item and no result accepted
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hand one item over, with random idle cycles ahead of it
    // start stays high on return; whoever pauses next drops it
    task automatic send_item(input op_t op, input logic [15:0] tag, input logic s,
                             input logic w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= '{opcode: op, request_tag: tag, is_sync: s, is_write: w};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // wait until the block is idle, then write one register
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] e0, input logic [15:0] e1,
                             input logic [15:0] e2, input logic [15:0] e3,
                             input logic [15:0] bl, input logic [15:0] sl);
        write_reg(REG_SYNC_RD_EXP, e0);
        write_reg(REG_SYNC_WR_EXP, e1);
        write_reg(REG_ASYNC_RD_EXP, e2);
        write_reg(REG_ASYNC_WR_EXP, e3);
        write_reg(REG_BATCH_LIMIT, bl);
        write_reg(REG_STARVE_LIMIT, sl);
    endtask

    // mostly enqueues and dispatches with a few ticks, so queues fill and drain
    task automatic random_items(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 15)
                send_item(OP_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
            else if (k < 55)
                send_item(OP_ENQ, 16'($urandom), 1'($urandom), 1'($urandom));
            else if (k < 97)
                send_item(OP_DISP, 16'($urandom), 1'($urandom), 1'($urandom));
            else
                send_item(OP_NONE, 16'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 12;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dispatch, unused opcode, tag extremes on every class
        send_item(OP_DISP, 16'h0000, 1'b0, 1'b0);
        send_item(OP_NONE, 16'hFFFF, 1'b1, 1'b1);
        for (int q = 0; q < 4; q++)
        begin
            send_item(OP_ENQ, 16'hFFFF, q[1], q[0]);
            send_item(OP_ENQ, 16'h0000, q[1], q[0]);
        end
        send_item(OP_TICK, 16'h0, 1'b0, 1'b0);
        for (int i = 0; i < 9; i++)
            send_item(OP_DISP, 16'h0, 1'b0, 1'b0);

        // full queue: fill one class past its depth, then drain it
        for (int i = 0; i < 66; i++)
            send_item(OP_ENQ, 16'(i), 1'b1, 1'b0);
        for (int i = 0; i < 66; i++)
            send_item(OP_DISP, 16'h0, 1'b0, 1'b0);

        // zero expiries and batch limit: a dispatch after a dispatched request runs the expired check
        write_all(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        random_items(400);

        // hold off until everything has come back
        drain();
        idle_pct = 48;
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF);
        random_items(400);

        idle_pct = 0;
        write_all(16'd3, 16'd5, 16'd7, 16'd2, 16'd2, 16'd3);
        random_items(350);

        // expiries near half range exercise the wrap-aware expired compare
        write_all(16'h8000, 16'h7FFF, 16'h1, 16'hFFFE, 16'h1, 16'h2);
        random_items(300);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
